// ----- sv/rrkb_pkg.sv -----
// Shared types and constants for the round-robin k-best resource block scheduler.
// No dependencies; every module of the block imports this package.
package rrkb_pkg;

   localparam int MAX_STATIONS = 16;
   localparam int MAX_BLOCKS   = 32;
   localparam int ST_W         = $clog2(MAX_STATIONS);
   localparam int BLK_W        = $clog2(MAX_BLOCKS);
   localparam int ADDR_W       = 1 + ST_W + BLK_W;
   localparam int SINR_W       = 16;

   // Command codes.
   localparam logic [1:0] CMD_STORE    = 2'd0;
   localparam logic [1:0] CMD_REQUEST  = 2'd1;
   localparam logic [1:0] CMD_SCHEDULE = 2'd2;

   // Band codes.
   localparam logic [1:0] BAND_UP   = 2'd0;
   localparam logic [1:0] BAND_DOWN = 2'd1;
   localparam logic [1:0] BAND_D2D  = 2'd2;

   // Configuration register indexes.
   localparam logic [2:0] REG_STATION_COUNT = 3'd0;
   localparam logic [2:0] REG_UP_RB_COUNT   = 3'd1;
   localparam logic [2:0] REG_DOWN_RB_COUNT = 3'd2;
   localparam logic [2:0] REG_UP_K          = 3'd3;
   localparam logic [2:0] REG_DOWN_K        = 3'd4;

   typedef enum logic [2:0] {
      S_IDLE,
      S_INIT,
      S_VISIT,
      S_SCAN,
      S_GRANT,
      S_NEXT,
      S_FINISH
   } state_type;

   // One result beat.
   typedef struct packed {
      logic            granted;
      logic [BLK_W-1:0] block_res;
      logic            band_res;
      logic [ST_W-1:0] station_res;
   } result_type;

endpackage

// ----- sv/rrkb_sinr_mem.sv -----
// SINR estimate memory for both bands, addressed {band, station, block}.
// One write port and one registered read port. Depends on rrkb_pkg.
module rrkb_sinr_mem (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [rrkb_pkg::ADDR_W-1:0] wr_addr,
   input  logic [rrkb_pkg::SINR_W-1:0] wr_data,
   input  logic                       rd_en,
   input  logic [rrkb_pkg::ADDR_W-1:0] rd_addr,
   output logic [rrkb_pkg::SINR_W-1:0] rd_data
);
   import rrkb_pkg::*;

   logic [SINR_W-1:0] mem_ff [2**ADDR_W];
   logic [SINR_W-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- sv/rrkb_best_unit.sv -----
// Shared compare unit: keeps the best free block seen during one scan.
// Strictly greater wins, so ties keep the lower block index. Depends on rrkb_pkg.
module rrkb_best_unit (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       clear,
   input  logic                       cmp_en,
   input  logic [rrkb_pkg::BLK_W-1:0]  cmp_blk,
   input  logic [rrkb_pkg::SINR_W-1:0] cmp_val,
   output logic                       best_vld,
   output logic [rrkb_pkg::BLK_W-1:0]  best_blk
);
   import rrkb_pkg::*;

   logic              best_vld_ff, best_vld_in;
   logic [BLK_W-1:0]  best_blk_ff, best_blk_in;
   logic [SINR_W-1:0] best_val_ff, best_val_in;

   // Compare the candidate against the running best.
   always_comb begin
      best_vld_in = best_vld_ff;
      best_blk_in = best_blk_ff;
      best_val_in = best_val_ff;
      if (clear) begin
         best_vld_in = 1'b0;
      end else if (cmp_en && (!best_vld_ff || $signed(cmp_val) > $signed(best_val_ff))) begin
         best_vld_in = 1'b1;
         best_blk_in = cmp_blk;
         best_val_in = cmp_val;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         best_vld_ff <= 1'b0;
      end else begin
         best_vld_ff <= best_vld_in;
      end
      best_blk_ff <= best_blk_in;
      best_val_ff <= best_val_in;
   end

   assign best_vld = best_vld_ff;
   assign best_blk = best_blk_ff;

endmodule

// ----- sv/round_robin_k_best_rb_scheduler.sv -----
// Top level of the round-robin k-best resource block scheduler: sequencer,
// request and pointer state, configuration and result register.
// Depends on rrkb_pkg, rrkb_sinr_mem and rrkb_best_unit.
//
// Channel | Direction | Beat contents
// req_    | in        | tdata: cmd, station, band, block, sinr
// rsp_    | out       | tdata: station_res, band_res, block_res, granted; tlast: last
// csr_    | in        | write enable, register index, write data
//
// Store and request beats are taken in the idle state, which the block does not
// leave for them. A schedule beat scans the blocks of each visited origin one at
// a time through the single memory read port feeding the shared compare unit.
// The input is not ready while a schedule runs. A result waiting in the
// output register stalls the sequencer only when a new result must be moved.
// Reset is synchronous; the SINR memory is not cleared.
module round_robin_k_best_rb_scheduler (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [1:0] cmd, [5:2] station, [7:6] band, [12:8] block, [28:13] sinr
   input  logic [31:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [3:0] station_res, [4] band_res, [9:5] block_res, [10] granted
   output logic [15:0] rsp_tdata,
   output logic        rsp_tlast,
   input  logic        csr_we,
   input  logic [2:0]  csr_addr,
   input  logic [5:0]  csr_wdata
);
   import rrkb_pkg::*;

   // Input fields.
   logic [1:0]        in_cmd;
   logic [ST_W-1:0]   in_station;
   logic [1:0]        in_band;
   logic [BLK_W-1:0]  in_block;
   logic [SINR_W-1:0] in_sinr;
   assign in_cmd     = req_tdata[1:0];
   assign in_station = req_tdata[5:2];
   assign in_band    = req_tdata[7:6];
   assign in_block   = req_tdata[12:8];
   assign in_sinr    = req_tdata[28:13];

   // Configuration registers.
   logic [3:0] sc_ff;
   logic [5:0] up_rb_ff, dn_rb_ff, up_k_ff, dn_k_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sc_ff    <= 4'd15;
         up_rb_ff <= 6'd25;
         dn_rb_ff <= 6'd25;
         up_k_ff  <= 6'd1;
         dn_k_ff  <= 6'd1;
      end else if (csr_we) begin
         unique case (csr_addr)
            REG_STATION_COUNT: sc_ff    <= csr_wdata[3:0];
            REG_UP_RB_COUNT:   up_rb_ff <= csr_wdata;
            REG_DOWN_RB_COUNT: dn_rb_ff <= csr_wdata;
            REG_UP_K:          up_k_ff  <= csr_wdata;
            REG_DOWN_K:        dn_k_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Sequencer state.
   state_type         state_ff, state_in;
   logic              band_ff, band_in;
   logic [4:0]        it_ff, it_in;
   logic              assigned_ff, assigned_in;
   logic [5:0]        rem_ff, rem_in;
   logic [MAX_BLOCKS-1:0] free_ff, free_in;
   logic [5:0]        g_ff, g_in;
   logic [5:0]        b_ff, b_in;
   logic [4:0]        up_ptr_ff, up_ptr_in, dn_ptr_ff, dn_ptr_in;
   logic [MAX_STATIONS-1:0] req_up_ff, req_up_in, req_dn_ff, req_dn_in;
   logic              pend_vld_ff, pend_vld_in;
   result_type        pend_ff, pend_in;
   logic              rsp_vld_ff, rsp_vld_in;
   result_type        rsp_ff, rsp_in;
   logic              rsp_last_ff, rsp_last_in;

   // Band-dependent values.
   logic [5:0] rb_raw, rb_eff, k_cur;
   logic [4:0] origins, ptr_cur;
   logic       req_cur;
   logic       out_free;
   logic [4:0] bm1;

   assign rb_raw  = band_ff ? dn_rb_ff : up_rb_ff;
   assign rb_eff  = (rb_raw > 6'(MAX_BLOCKS)) ? 6'(MAX_BLOCKS) : rb_raw;
   assign k_cur   = band_ff ? dn_k_ff : up_k_ff;
   assign origins = {1'b0, sc_ff} + 5'd1;
   assign ptr_cur = band_ff ? dn_ptr_ff : up_ptr_ff;
   assign req_cur = band_ff ? req_dn_ff[it_ff[3:0]] : req_up_ff[it_ff[3:0]];
   assign out_free = !rsp_vld_ff || rsp_tready;
   assign bm1     = 5'(b_ff - 6'd1);

   // Memory and compare unit hookup.
   logic              mem_we, mem_re, best_vld, cmp_en, best_clear;
   logic [ADDR_W-1:0] mem_waddr, mem_raddr;
   logic [SINR_W-1:0] mem_rdata;
   logic [BLK_W-1:0]  best_blk;

   assign mem_we    = req_tvalid && req_tready && in_cmd == CMD_STORE &&
                      (in_band == BAND_UP || in_band == BAND_DOWN);
   assign mem_waddr = {in_band[0], in_station, in_block};
   assign mem_re    = state_ff == S_SCAN && b_ff < rb_eff;
   assign mem_raddr = {band_ff, it_ff[3:0], b_ff[4:0]};
   assign cmp_en    = state_ff == S_SCAN && b_ff != 6'd0 && free_ff[bm1];
   assign best_clear = state_ff == S_SCAN && b_ff == 6'd0;

   rrkb_sinr_mem u_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (in_sinr),
      .rd_en   (mem_re),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   rrkb_best_unit u_best (
      .clock    (clock),
      .reset    (reset),
      .clear    (best_clear),
      .cmp_en   (cmp_en),
      .cmp_blk  (bm1),
      .cmp_val  (mem_rdata),
      .best_vld (best_vld),
      .best_blk (best_blk)
   );

   assign req_tready = state_ff == S_IDLE;

   // Next state and datapath control.
   always_comb begin
      state_in    = state_ff;
      band_in     = band_ff;
      it_in       = it_ff;
      assigned_in = assigned_ff;
      rem_in      = rem_ff;
      free_in     = free_ff;
      g_in        = g_ff;
      b_in        = b_ff;
      up_ptr_in   = up_ptr_ff;
      dn_ptr_in   = dn_ptr_ff;
      req_up_in   = req_up_ff;
      req_dn_in   = req_dn_ff;
      pend_vld_in = pend_vld_ff;
      pend_in     = pend_ff;
      rsp_vld_in  = rsp_vld_ff && !rsp_tready;
      rsp_in      = rsp_ff;
      rsp_last_in = rsp_last_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               if (in_cmd == CMD_REQUEST) begin
                  if (in_band == BAND_UP || in_band == BAND_D2D) begin
                     req_up_in[in_station] = 1'b1;
                  end
                  if (in_band == BAND_DOWN || in_band == BAND_D2D) begin
                     req_dn_in[in_station] = 1'b1;
                  end
               end else if (in_cmd == CMD_SCHEDULE) begin
                  band_in = 1'b0;
                  state_in = (req_up_ff != '0 || req_dn_ff != '0) ? S_INIT : S_FINISH;
               end
            end
         end
         S_INIT: begin
            if (k_cur == 6'd0) begin
               state_in = S_NEXT;
            end else begin
               it_in       = (ptr_cur > origins) ? origins : ptr_cur;
               rem_in      = rb_eff;
               free_in     = (rb_eff == 6'(MAX_BLOCKS)) ? '1 :
                             ((MAX_BLOCKS)'(1) << rb_eff) - (MAX_BLOCKS)'(1);
               assigned_in = 1'b1;
               state_in    = S_VISIT;
            end
         end
         S_VISIT: begin
            priority if (rem_ff < k_cur) begin
               if (band_ff) dn_ptr_in = it_ff;
               else         up_ptr_in = it_ff;
               state_in = S_NEXT;
            end else if (it_ff == origins) begin
               it_in = 5'd0;
               if (assigned_ff) begin
                  assigned_in = 1'b0;
               end else begin
                  if (band_ff) dn_ptr_in = 5'd0;
                  else         up_ptr_in = 5'd0;
                  state_in = S_NEXT;
               end
            end else if (!req_cur || (it_ff == 5'd0 && !band_ff)) begin
               it_in = it_ff + 5'd1;
            end else begin
               g_in     = 6'd0;
               b_in     = 6'd0;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            b_in = b_ff + 6'd1;
            if (b_ff == rb_eff) begin
               state_in = S_GRANT;
            end
         end
         S_GRANT: begin
            if (!pend_vld_ff || out_free) begin
               if (pend_vld_ff) begin
                  rsp_vld_in  = 1'b1;
                  rsp_in      = pend_ff;
                  rsp_last_in = 1'b0;
               end
               pend_vld_in         = 1'b1;
               pend_in.station_res = it_ff[3:0];
               pend_in.band_res    = band_ff;
               pend_in.block_res   = best_blk;
               pend_in.granted     = 1'b1;
               free_in[best_blk]   = 1'b0;
               if (g_ff + 6'd1 == k_cur) begin
                  rem_in      = rem_ff - k_cur;
                  it_in       = it_ff + 5'd1;
                  assigned_in = 1'b1;
                  state_in    = S_VISIT;
               end else begin
                  g_in     = g_ff + 6'd1;
                  b_in     = 6'd0;
                  state_in = S_SCAN;
               end
            end
         end
         S_NEXT: begin
            if (!band_ff) begin
               band_in  = 1'b1;
               state_in = S_INIT;
            end else begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (out_free) begin
               rsp_vld_in  = 1'b1;
               rsp_last_in = 1'b1;
               rsp_in      = pend_vld_ff ? pend_ff : '0;
               pend_vld_in = 1'b0;
               req_up_in   = '0;
               req_dn_in   = '0;
               state_in    = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         up_ptr_ff   <= 5'd0;
         dn_ptr_ff   <= 5'd0;
         req_up_ff   <= '0;
         req_dn_ff   <= '0;
         pend_vld_ff <= 1'b0;
         rsp_vld_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         up_ptr_ff   <= up_ptr_in;
         dn_ptr_ff   <= dn_ptr_in;
         req_up_ff   <= req_up_in;
         req_dn_ff   <= req_dn_in;
         pend_vld_ff <= pend_vld_in;
         rsp_vld_ff  <= rsp_vld_in;
      end
      band_ff     <= band_in;
      it_ff       <= it_in;
      assigned_ff <= assigned_in;
      rem_ff      <= rem_in;
      free_ff     <= free_in;
      g_ff        <= g_in;
      b_ff        <= b_in;
      pend_ff     <= pend_in;
      rsp_ff      <= rsp_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {5'd0, rsp_ff};
   assign rsp_tlast  = rsp_last_ff;

   // A grant always finds a free block.
   a_grant_has_block: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_GRANT |-> best_vld)
      else $error("grant without a free block");

   // The remaining block count in the visit state never exceeds MAX_BLOCKS.
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_VISIT |-> rem_ff <= 6'(MAX_BLOCKS))
      else $error("remaining block count out of range");

   // A schedule run ends with a last beat loaded into the output register.
   a_finish_last: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_FINISH && out_free |=> rsp_vld_ff && rsp_last_ff)
      else $error("schedule finished without a last beat");

endmodule

// ----- dv/tb.sv -----
// Self-checking testbench for round_robin_k_best_rb_scheduler: drives store,
// request and schedule beats, predicts every grant and checks the result stream.
// Depends on rrkb_pkg and the scheduler RTL.
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import rrkb_pkg::*;

   // Codes the block ignores.
   localparam logic [1:0] CMD_UNKNOWN = 2'd3;
   localparam logic [1:0] BAND_NONE   = 2'd3;

   // One expected grant beat with its end-of-run marker.
   typedef struct {
      logic [3:0] station_res;
      logic       band_res;
      logic [4:0] block_res;
      logic       granted;
      logic       last;
   } grant_beat_type;

   // Grant predictor and scoreboard.
   class grant_scoreboard_type;
      logic signed [15:0] est_up[16][32];
      logic signed [15:0] est_down[16][32];
      bit [15:0]  want_up, want_down;
      int         ptr_up, ptr_down;
      int         n_mobiles, rbs_up, rbs_down, k_up, k_down;
      grant_beat_type grants_due[$];
      int         errors, grants_seen, runs;

      function new();
         n_mobiles = 15; rbs_up = 25; rbs_down = 25; k_up = 1; k_down = 1;
      endfunction

      function void set_reg(logic [2:0] idx, logic [5:0] val);
         case (idx)
            REG_STATION_COUNT: n_mobiles = int'(val[3:0]);
            REG_UP_RB_COUNT:   rbs_up = int'(val);
            REG_DOWN_RB_COUNT: rbs_down = int'(val);
            REG_UP_K:          k_up = int'(val);
            REG_DOWN_K:        k_down = int'(val);
            default: ;
         endcase
      endfunction

      // Serve one band and queue its grants; returns the number of grants.
      function int serve_band(bit dir);
         int rb, k, origins, remaining, it, best, bestv, n;
         bit [31:0] free_rb;
         bit [15:0] want;
         bit served;
         grant_beat_type g;
         rb = dir ? rbs_down : rbs_up;
         k = dir ? k_down : k_up;
         want = dir ? want_down : want_up;
         if (rb > MAX_BLOCKS) rb = MAX_BLOCKS;
         origins = n_mobiles + 1;
         free_rb = (rb == 32) ? '1 : ((32'd1 << rb) - 32'd1);
         remaining = rb;
         n = 0;
         served = 1;
         if (k == 0) return 0;
         it = dir ? ptr_down : ptr_up;
         if (it > origins) it = origins;
         while (remaining >= k) begin
            if (it == origins) begin
               it = 0;
               if (!served) break;
               served = 0;
            end
            if (!want[it] || (it == 0 && !dir)) begin
               it++;
               continue;
            end
            for (int j = 0; j < k; j++) begin
               best = -1;
               bestv = 0;
               for (int b = 0; b < rb; b++) begin
                  if (free_rb[b]) begin
                     int v;
                     v = dir ? est_down[it][b] : est_up[it][b];
                     if (best < 0 || v > bestv) begin
                        best = b;
                        bestv = v;
                     end
                  end
               end
               if (best < 0) break;
               free_rb[best] = 1'b0;
               g.station_res = 4'(it); g.band_res = dir; g.block_res = 5'(best);
               g.granted = 1; g.last = 0;
               grants_due = {grants_due, g};
               n++;
            end
            remaining -= k;
            it++;
            served = 1;
         end
         if (dir) ptr_down = it; else ptr_up = it;
         return n;
      endfunction

      // Note one accepted input beat.
      function void note_input(logic [31:0] d);
         logic [1:0] cmd, band;
         logic [3:0] st;
         logic [4:0] blk;
         int n;
         grant_beat_type g;
         cmd = d[1:0]; st = d[5:2]; band = d[7:6]; blk = d[12:8];
         case (cmd)
            CMD_STORE: begin
               if (band == BAND_UP) est_up[st][blk] = d[28:13];
               else if (band == BAND_DOWN) est_down[st][blk] = d[28:13];
            end
            CMD_REQUEST: begin
               if (band == BAND_UP || band == BAND_D2D) want_up[st] = 1;
               if (band == BAND_DOWN || band == BAND_D2D) want_down[st] = 1;
            end
            CMD_SCHEDULE: begin
               n = 0;
               runs++;
               if (want_up != 0 || want_down != 0) begin
                  n = serve_band(0);
                  n += serve_band(1);
               end
               want_up = 0;
               want_down = 0;
               if (n == 0) begin
                  g = '{default: 0};
                  grants_due = {grants_due, g};
               end
               grants_due[grants_due.size()-1].last = 1;
            end
            default: ;
         endcase
      endfunction

      // Compare one accepted result beat with the oldest expectation.
      function void check_result(logic [15:0] d, logic l);
         grant_beat_type g;
         if (grants_due.size() == 0) begin
            $display("%0t: unexpected result beat %h last %b", $time, d, l);
            errors++;
            return;
         end
         g = grants_due.pop_front();
         grants_seen++;
         if (d[3:0] !== g.station_res || d[4] !== g.band_res ||
             d[9:5] !== g.block_res || d[10] !== g.granted || l !== g.last) begin
            $display("%0t: mismatch expected st %0d band %0d blk %0d gr %0d last %0d",
                     $time, g.station_res, g.band_res, g.block_res, g.granted, g.last);
            $display("%0t:          actual   st %0d band %0d blk %0d gr %0d last %0d",
                     $time, d[3:0], d[4], d[9:5], d[10], l);
            errors++;
         end
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [15:0] rsp_tdata;
   logic        rsp_tlast;
   logic        csr_we = 0;
   logic [2:0]  csr_addr = '0;
   logic [5:0]  csr_wdata = '0;

   grant_scoreboard_type sb = new();
   bit  calm = 0;
   int  idle_cycles = 0;
   int  rsp_hold = 0;

   round_robin_k_best_rb_scheduler dut (.*);

   always begin
      #10 clock = 1;
      #10 clock = 0;
   end

   // Mostly no gap, some short ones and a few long ones; none in calm stretches.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(99);
      if (calm || r < 60) return 0;
      if (r < 92) return $urandom_range(3, 1);
      return $urandom_range(40, 10);
   endfunction

   // Result side: random back-pressure, checking and the watchdog.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata, rsp_tlast);
         if ((rsp_tvalid && rsp_tready) || (req_tvalid && req_tready)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (idle_cycles > 20000) begin
            $display("%0t: watchdog expired", $time);
            $display("*** FAILED ***");
            $finish;
         end
         if (rsp_hold > 0) begin
            rsp_tready <= 0;
            rsp_hold <= rsp_hold - 1;
         end else begin
            rsp_tready <= 1;
            if (!calm && $urandom_range(99) < 25) rsp_hold <= pick_gap();
         end
      end
   end

   // Send one input beat and wait for it to be taken.
   task automatic send_beat(logic [1:0] cmd, logic [3:0] st, logic [1:0] band,
                            logic [4:0] blk, logic [15:0] sinr);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= {3'b000, sinr, blk, band, st, cmd};
      do @(posedge clock); while (!req_tready);
      sb.note_input(req_tdata);
   endtask

   // Drain all results, then let the block settle before register writes.
   task automatic drain();
      req_tvalid <= 0;
      while (sb.grants_due.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic write_regs(int sc, int ru, int rd, int ku, int kd);
      int vals[5];
      vals = '{sc, ru, rd, ku, kd};
      for (int i = 0; i < 5; i++) begin
         csr_we <= 1;
         csr_addr <= 3'(i);
         csr_wdata <= 6'(vals[i]);
         @(posedge clock);
         sb.set_reg(3'(i), 6'(vals[i]));
      end
      csr_we <= 0;
      @(posedge clock);
   endtask

   // Random mix; requests only come from origins whose estimates are filled.
   task automatic random_beats(int count);
      int r;
      for (int i = 0; i < count; i++) begin
         r = $urandom_range(99);
         if (r < 35)
            send_beat(CMD_STORE, 4'($urandom), 2'($urandom), 5'($urandom),
                      16'($urandom));
         else if (r < 80)
            send_beat(CMD_REQUEST, 4'($urandom_range(2)), 2'($urandom_range(3)),
                      5'd0, 16'($urandom));
         else if (r < 96)
            send_beat(CMD_SCHEDULE, 4'($urandom), 2'($urandom), 5'($urandom),
                      16'($urandom));
         else
            send_beat(CMD_UNKNOWN, 4'($urandom), 2'($urandom), 5'($urandom),
                      16'($urandom));
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Fill the estimates that origins 0 to 2 can ever have read.
      calm = 1;
      for (int b = 0; b < 32; b++)
         send_beat(CMD_STORE, 4'd0, BAND_DOWN, 5'(b), 16'($urandom));
      for (int s = 1; s < 3; s++)
         for (int b = 0; b < 32; b++) begin
            send_beat(CMD_STORE, 4'(s), BAND_UP, 5'(b), 16'($urandom));
            send_beat(CMD_STORE, 4'(s), BAND_DOWN, 5'(b), 16'($urandom));
         end
      calm = 0;

      // Directed: empty schedule, ties, extremes, all bands and commands.
      send_beat(CMD_SCHEDULE, 4'd0, BAND_UP, 5'd0, 16'd0);
      send_beat(CMD_STORE, 4'd1, BAND_UP, 5'd0, 16'h7fff);
      send_beat(CMD_STORE, 4'd1, BAND_UP, 5'd31, 16'h7fff);
      send_beat(CMD_STORE, 4'd2, BAND_DOWN, 5'd5, 16'h8000);
      send_beat(CMD_STORE, 4'd3, BAND_NONE, 5'd7, 16'h1234);
      send_beat(CMD_STORE, 4'd15, BAND_D2D, 5'd31, 16'hffff);
      send_beat(CMD_UNKNOWN, 4'd15, BAND_NONE, 5'd31, 16'hffff);
      send_beat(CMD_REQUEST, 4'd0, BAND_D2D, 5'd0, 16'd0);
      send_beat(CMD_REQUEST, 4'd1, BAND_UP, 5'd0, 16'd0);
      send_beat(CMD_REQUEST, 4'd2, BAND_DOWN, 5'd0, 16'd0);
      send_beat(CMD_REQUEST, 4'd7, BAND_NONE, 5'd0, 16'd0);
      send_beat(CMD_SCHEDULE, 4'd0, BAND_UP, 5'd0, 16'd0);
      for (int s = 0; s < 3; s++) send_beat(CMD_REQUEST, 4'(s), BAND_D2D, 5'd0, 16'd0);
      send_beat(CMD_SCHEDULE, 4'd0, BAND_UP, 5'd0, 16'd0);
      drain();

      // Register settings, extremes and out-of-range values included.
      write_regs(15, 32, 32, 32, 32);  random_beats(12); drain();
      write_regs(1, 1, 1, 1, 1);       random_beats(12); drain();
      write_regs(3, 8, 5, 2, 3);       calm = 1; random_beats(12); calm = 0; drain();
      write_regs(0, 63, 0, 0, 40);     random_beats(12); drain();
      write_regs(15, 4, 32, 1, 5);     random_beats(12); drain();
      write_regs(2, 32, 17, 9, 33);    random_beats(12); drain();
      write_regs(15, 25, 25, 1, 1);    random_beats(12); drain();

      repeat (50) @(posedge clock);
      $display("Covered %0d schedule runs with %0d result beats over seven settings.",
               sb.runs, sb.grants_seen);
      if (sb.errors == 0 && sb.grants_due.size() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end
endmodule

// ----- sim.f -----
sv/rrkb_pkg.sv
sv/rrkb_sinr_mem.sv
sv/rrkb_best_unit.sv
sv/round_robin_k_best_rb_scheduler.sv
dv/tb.sv
